/* rtl/byte_ring_fifo_with_messages_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the byte ring FIFO
// Both macros expect signals named clk and rst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_WITH_MESSAGES_MACROS_SVH
`define BYTE_RING_FIFO_WITH_MESSAGES_MACROS_SVH

// Plain clocked property, disabled while in reset.
`define BRFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define BRFM_ASSERT_IMPL(lbl, ante, cons, msg) \
  `BRFM_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* rtl/brfm_pkg.sv */
// ----------------------------------------------------------------------------
// brfm_pkg
// Types, codes and ring helpers shared by the byte ring FIFO.
// ----------------------------------------------------------------------------
package brfm_pkg;

  localparam int SLOTS  = 64;
  localparam int PTR_W  = $clog2(SLOTS);
  localparam int CNT_W  = 6;
  localparam int DATA_W = 8;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  // Opcodes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_MSG   = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic [DATA_W-1:0] NUL_BYTE = 8'h00;

  // Index of the last result a message read may give before the forced stop
  localparam logic [CNT_W-1:0] MSG_LAST_K = 6'd63;

  localparam logic [CNT_W-1:0] CAP_RESET = 6'd63;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] byte_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } ring_cmd_t;

  // cur_* describe the ring now; count..full describe it after the command
  typedef struct packed {
    ptr_t rp;
    ptr_t wp;
    ptr_t rp_nxt;
    logic cur_empty;
    logic cur_full;
    cnt_t count;
    cnt_t space;
    logic empty;
    logic full;
  } ring_view_t;

  function automatic ptr_t next_pos(ptr_t p, cnt_t cap);
    ptr_t r;
    if (CNT_W'(p) >= cap) r = '0;
    else                  r = p + 1'b1;
    return r;
  endfunction

  function automatic cnt_t held(ptr_t rp, ptr_t wp, cnt_t cap);
    logic [CNT_W:0] t;
    if (wp < rp) t = {1'b0, cap} + 1'b1 - (CNT_W+1)'(rp) + (CNT_W+1)'(wp);
    else         t = (CNT_W+1)'(wp) - (CNT_W+1)'(rp);
    return t[CNT_W-1:0];
  endfunction

endpackage

/* rtl/brfm_ifs.sv */
// ----------------------------------------------------------------------------
// brfm channel interfaces
// Request channel into the FIFO and result channel out of it.
// ----------------------------------------------------------------------------
interface brfm_in_if;
  logic                        valid;
  logic                        ready;
  logic [brfm_pkg::OP_W-1:0]   opcode;
  logic [brfm_pkg::DATA_W-1:0] data_in;

  modport source (output valid, output opcode, output data_in, input ready);
  modport sink   (input valid, input opcode, input data_in, output ready);
endinterface

interface brfm_out_if;
  logic                        valid;
  logic                        ready;
  logic [brfm_pkg::DATA_W-1:0] data_out;
  logic [brfm_pkg::STAT_W-1:0] status;
  logic [brfm_pkg::CNT_W-1:0]  count;
  logic [brfm_pkg::CNT_W-1:0]  space;
  logic                        is_empty;
  logic                        is_full;
  logic                        last;

  modport source (output valid, output data_out, output status, output count,
                  output space, output is_empty, output is_full, output last,
                  input ready);
  modport sink   (input valid, input data_out, input status, input count,
                  input space, input is_empty, input is_full, input last,
                  output ready);
endinterface

/* rtl/byte_ring_fifo_with_messages.sv */
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_messages
// Byte FIFO on a ring of capacity+1 slots with byte, message and clear requests.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  in_ch   | in  | valid/ready        | opcode, data_in
//  out_ch  | out | valid/ready        | data_out, status, count, space,
//          |     |                    | is_empty, is_full, last
//  cfg     | in  | cfg_we (no ready)  | cfg_data = capacity
//
//  Write, clear, empty read: IDLE (accept), EXEC (execute). Byte read: IDLE,
//  EXEC, RDATA. Message read: IDLE, EXEC, an RDATA step for each byte taken (NUL
//  included), EXEC again if the ring runs dry first. Store: one registered read port.
//  One request in flight; the next is accepted while the last result waits
//  in the output register. Execution stalls only while that register is full.
//  Reset (rst_n low, synchronous) empties the ring and sets capacity to 63.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_messages (
  input  logic                clk,
  input  logic                rst_n,
  brfm_in_if.sink             in_ch,
  brfm_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [brfm_pkg::CNT_W-1:0] cfg_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_RDATA = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [brfm_pkg::OP_W-1:0]   op_r, op_nxt;
  brfm_pkg::byte_t             din_r, din_nxt;
  brfm_pkg::cnt_t              k_r, k_nxt;

  logic                        out_valid_r, out_valid_nxt;
  brfm_pkg::byte_t             out_data_r;
  logic [brfm_pkg::STAT_W-1:0] out_status_r;
  brfm_pkg::cnt_t              out_count_r;
  brfm_pkg::cnt_t              out_space_r;
  logic                        out_empty_r;
  logic                        out_full_r;
  logic                        out_last_r;

  logic                        out_free;
  logic                        emit;
  brfm_pkg::byte_t             e_data;
  logic [brfm_pkg::STAT_W-1:0] e_status;
  logic                        e_last;

  brfm_pkg::ring_cmd_t         cmd;
  brfm_pkg::ring_view_t        view;
  logic                        mem_re;
  brfm_pkg::ptr_t              mem_raddr;
  brfm_pkg::byte_t             rd_data;

  brfm_ring u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .view     (view)
  );

  brfm_store u_store (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (view.wp),
    .wdata (din_r),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    din_nxt   = din_r;
    k_nxt     = k_r;
    cmd       = '0;
    mem_re    = 1'b0;
    mem_raddr = view.rp;
    emit      = 1'b0;
    e_data    = brfm_pkg::NUL_BYTE;
    e_status  = brfm_pkg::ST_OK;
    e_last    = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.opcode;
          din_nxt   = in_ch.data_in;
          k_nxt     = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          unique case (op_r)
            brfm_pkg::OP_WRITE: begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (view.cur_full) e_status = brfm_pkg::ST_FULL;
              else               cmd.push = 1'b1;
            end
            brfm_pkg::OP_READ, brfm_pkg::OP_MSG: begin
              if (view.cur_empty) begin
                emit      = 1'b1;
                e_status  = brfm_pkg::ST_EMPTY;
                state_nxt = S_IDLE;
              end else begin
                mem_re    = 1'b1;
                state_nxt = S_RDATA;
              end
            end
            brfm_pkg::OP_CLEAR: begin
              cmd.clear = 1'b1;
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_RDATA: begin
        if (out_free) begin
          // the byte at the read position is consumed in every branch
          cmd.pop = 1'b1;
          emit    = 1'b1;
          priority if (op_r == brfm_pkg::OP_READ) begin
            e_data    = rd_data;
            state_nxt = S_IDLE;
          end else if (k_r == brfm_pkg::MSG_LAST_K) begin
            // forced stop: terminator expected here
            e_status  = (rd_data == brfm_pkg::NUL_BYTE) ? brfm_pkg::ST_OK
                                                         : brfm_pkg::ST_EMPTY;
            state_nxt = S_IDLE;
          end else if (rd_data == brfm_pkg::NUL_BYTE) begin
            state_nxt = S_IDLE;
          end else begin
            e_data = rd_data;
            e_last = 1'b0;
            k_nxt  = k_r + 1'b1;
            if (view.empty) begin
              // ring ran dry mid-message: EXEC reports the error
              state_nxt = S_EXEC;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = view.rp_nxt;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit)              out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
    else                   out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    din_r <= din_nxt;
    k_r   <= k_nxt;
    if (emit) begin
      out_data_r   <= e_data;
      out_status_r <= e_status;
      out_count_r  <= view.count;
      out_space_r  <= view.space;
      out_empty_r  <= view.empty;
      out_full_r   <= view.full;
      out_last_r   <= e_last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.data_out = out_data_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.count    = out_count_r;
  assign out_ch.space    = out_space_r;
  assign out_ch.is_empty = out_empty_r;
  assign out_ch.is_full  = out_full_r;
  assign out_ch.last     = out_last_r;

endmodule

/* rtl/brfm_store.sv */
// ----------------------------------------------------------------------------
// brfm_store
// Byte storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module brfm_store (
  input  logic            clk,
  input  logic            we,
  input  brfm_pkg::ptr_t  waddr,
  input  brfm_pkg::byte_t wdata,
  input  logic            re,
  input  brfm_pkg::ptr_t  raddr,
  output brfm_pkg::byte_t rdata
);

  brfm_pkg::byte_t mem_r [brfm_pkg::SLOTS];
  brfm_pkg::byte_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read data holds until the next read enable
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/brfm_ring.sv */
// ----------------------------------------------------------------------------
// brfm_ring
// Capacity register, read/write positions and the derived fill status.
// ----------------------------------------------------------------------------
module brfm_ring (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  brfm_pkg::cnt_t       cfg_data,
  input  brfm_pkg::ring_cmd_t  cmd,
  output brfm_pkg::ring_view_t view
);

  brfm_pkg::cnt_t cap_r, cap_nxt;
  brfm_pkg::ptr_t rp_r, rp_nxt;
  brfm_pkg::ptr_t wp_r, wp_nxt;
  brfm_pkg::cnt_t cnt_post;

  always_comb begin
    cap_nxt = cfg_we ? cfg_data : cap_r;
    rp_nxt  = rp_r;
    wp_nxt  = wp_r;
    // a capacity change restarts the ring
    if (cfg_we || cmd.clear) begin
      rp_nxt = '0;
      wp_nxt = '0;
    end else begin
      if (cmd.push) wp_nxt = brfm_pkg::next_pos(wp_r, cap_r);
      if (cmd.pop)  rp_nxt = brfm_pkg::next_pos(rp_r, cap_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= brfm_pkg::CAP_RESET;
      rp_r  <= '0;
      wp_r  <= '0;
    end else begin
      cap_r <= cap_nxt;
      rp_r  <= rp_nxt;
      wp_r  <= wp_nxt;
    end
  end

  assign cnt_post = brfm_pkg::held(rp_nxt, wp_nxt, cap_r);

  always_comb begin
    view.rp        = rp_r;
    view.wp        = wp_r;
    view.rp_nxt    = rp_nxt;
    view.cur_empty = (rp_r == wp_r);
    view.cur_full  = (brfm_pkg::next_pos(wp_r, cap_r) == rp_r);
    view.count     = cnt_post;
    view.space     = (cap_r >= cnt_post) ? (cap_r - cnt_post) : '0;
    view.empty     = (rp_nxt == wp_nxt);
    view.full      = (brfm_pkg::next_pos(wp_nxt, cap_r) == rp_nxt);
  end

endmodule

/* rtl/brfm_checker.sv */
// ----------------------------------------------------------------------------
// brfm_checker
// Port-level checks on the result channel of the byte ring FIFO.
// ----------------------------------------------------------------------------
`include "byte_ring_fifo_with_messages_macros.svh"

module brfm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [brfm_pkg::DATA_W-1:0] out_data_out,
  input logic [brfm_pkg::STAT_W-1:0] out_status,
  input logic [brfm_pkg::CNT_W-1:0]  out_count,
  input logic [brfm_pkg::CNT_W-1:0]  out_space,
  input logic                        out_is_empty,
  input logic                        out_is_full,
  input logic                        out_last
);

  // count plus space never exceeds the largest capacity
  `BRFM_ASSERT_IMPL(a_fill_sum, out_valid, (7'(out_count) + 7'(out_space)) <= 7'd63, "count plus space too large")
  `BRFM_ASSERT_IMPL(a_empty_count, out_valid && out_is_empty, out_count == '0, "empty with nonzero count")
  `BRFM_ASSERT_IMPL(a_full_space, out_valid && out_is_full, out_space == '0, "full with free space")
  // an error ends the request and carries no byte
  `BRFM_ASSERT_IMPL(a_err_final, out_valid && out_status != brfm_pkg::ST_OK, out_last && out_data_out == '0, "error result not final or nonzero")
  `BRFM_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_data_out) && $stable(out_last), "stalled result changed")

endmodule

bind byte_ring_fifo_with_messages brfm_checker u_brfm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_data_out (out_ch.data_out),
  .out_status   (out_ch.status),
  .out_count    (out_ch.count),
  .out_space    (out_ch.space),
  .out_is_empty (out_ch.is_empty),
  .out_is_full  (out_ch.is_full),
  .out_last     (out_ch.last)
);
